// File: rtl/core/plin_pkg.sv
// Shared constants and codes for the piecewise linear interpolator.
`default_nettype none
package plin_pkg;

	// Q16.16 value width
	localparam int VAL_W = 32;
	// width of a table breakpoint entry as stored: {y, x}
	localparam int ENTRY_W = 2 * VAL_W;
	// input field widths
	localparam int IDX_IN_W = 6;
	localparam int CNT_IN_W = 7;
	localparam int STATUS_W = 2;

	// slave tdata layout, lowest bit up
	localparam int S_DATA_W = 104;
	localparam int IDX_LSB = 0;
	localparam int PX_LSB = IDX_LSB + IDX_IN_W;
	localparam int PY_LSB = PX_LSB + VAL_W;
	localparam int QX_LSB = PY_LSB + VAL_W;
	localparam int EXT_BIT = QX_LSB + VAL_W;

	// request kinds (tuser)
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO_WIDTH = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;

	// restoring divider: 64-bit dividend, one quotient bit per cycle
	localparam int DIV_STEPS = 2 * VAL_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// points_in_use after reset
	localparam logic [CNT_IN_W-1:0] POINTS_RESET = 7'd2;

endpackage
`default_nettype wire

// File: rtl/core/piecewise_linear_interpolator_top.sv
// Piecewise linear interpolator: breakpoint table, interval search, slope divider.
//
// Usage:
//   s_axis carries one request per transaction. tuser = 0 loads breakpoint
//   point_index with (point_x, point_y); tuser = 1 queries the value at
//   query_x, extending the end segments when extrapolate is set and holding
//   the end values otherwise. Every request gives one m_axis transaction:
//   result_y in tdata, status in tuser (0 ok, 1 zero-width interval,
//   2 saturated). Loads answer result_y = 0, status 0.
//   cfg_wr_en/cfg_wr_data write points_in_use (values below 2 act as 2,
//   above MAX_POINTS as MAX_POINTS); write it only while the block is idle.
// Sequence:
//   A load goes straight to the finish state. A query compares query_x with
//   the last left breakpoint, then searches upward from entry 1, one entry per
//   cycle on the single RAM read port, fetches both interval ends and runs 64
//   restoring divider steps for the slope. A zero-width interval skips the
//   divider. s_axis_tready is high only in idle, which starts at the edge that
//   registers a result. A result waiting in the output register lets one more
//   request run; that one holds until the receiver takes the first.
//   Reset clears the handshake, sets points_in_use to 2 and leaves the table as is.
`default_nettype none
module piecewise_linear_interpolator_top #(
	parameter int MAX_POINTS = 64
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	// config
	input  wire                                    cfg_wr_en,
	input  wire [plin_pkg::CNT_IN_W-1:0]           cfg_wr_data,   // points_in_use
	// request stream
	input  wire                                    s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [5:0] point_index, [37:6] point_x, [69:38] point_y, [101:70] query_x,
	// [102] extrapolate, [103] zero
	input  wire [plin_pkg::S_DATA_W-1:0]           s_axis_tdata,
	input  wire                                    s_axis_tuser,  // [0] req_type
	// result stream
	output logic                                   m_axis_tvalid,
	input  wire                                    m_axis_tready,
	output logic [plin_pkg::VAL_W-1:0]             m_axis_tdata,  // [31:0] result_y
	output logic [plin_pkg::STATUS_W-1:0]          m_axis_tuser   // [1:0] status
);

	localparam int VW = plin_pkg::VAL_W;
	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int EW = (CW > plin_pkg::CNT_IN_W) ? CW : plin_pkg::CNT_IN_W;
	localparam int XW = IW + plin_pkg::IDX_IN_W;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_LAST   = 4'd1;
	localparam logic [3:0] ST_SRCH   = 4'd2;
	localparam logic [3:0] ST_FETCHL = 4'd3;
	localparam logic [3:0] ST_FETCHR = 4'd4;
	localparam logic [3:0] ST_PAIR   = 4'd5;
	localparam logic [3:0] ST_MUL    = 4'd6;
	localparam logic [3:0] ST_DIV    = 4'd7;
	localparam logic [3:0] ST_SUM    = 4'd8;
	localparam logic [3:0] ST_FINISH = 4'd9;

	logic [3:0] state_q;
	logic [plin_pkg::CNT_IN_W-1:0] points_in_use_q;
	logic out_valid_q;
	logic [VW-1:0] out_y_q;
	logic [plin_pkg::STATUS_W-1:0] out_status_q;

	// working registers
	logic signed [VW-1:0] x_q;
	logic ext_q;
	logic [IW-1:0] nm2_q;
	logic [IW-1:0] i_q;
	logic signed [VW-1:0] xl_q;
	logic signed [VW-1:0] yl_q;
	logic signed [VW:0] dx_q;
	logic signed [VW:0] dy_q;
	logic signed [VW:0] ddx_q;
	logic neg_q;
	logic [2*VW-1:0] num_q;      // dividend, becomes the quotient
	logic [VW-1:0] rem_q;
	logic [VW-1:0] div_q;
	logic [plin_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [VW-1:0] res_y_q;
	logic [plin_pkg::STATUS_W-1:0] res_status_q;

	// input fields
	logic [plin_pkg::IDX_IN_W-1:0] in_idx;
	logic signed [VW-1:0] in_px;
	logic signed [VW-1:0] in_py;
	logic signed [VW-1:0] in_qx;
	logic in_ext;

	assign in_idx = s_axis_tdata[plin_pkg::PX_LSB-1:plin_pkg::IDX_LSB];
	assign in_px  = s_axis_tdata[plin_pkg::PY_LSB-1:plin_pkg::PX_LSB];
	assign in_py  = s_axis_tdata[plin_pkg::QX_LSB-1:plin_pkg::PY_LSB];
	assign in_qx  = s_axis_tdata[plin_pkg::EXT_BIT-1:plin_pkg::QX_LSB];
	assign in_ext = s_axis_tdata[plin_pkg::EXT_BIT];

	logic s_fire;
	logic m_fire;
	logic finish_go;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign m_fire = out_valid_q && m_axis_tready;
	assign finish_go = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready);

	// clamp points_in_use to 2 .. MAX_POINTS
	logic [EW-1:0] pu_ext;
	logic [EW-1:0] n_c;
	logic [EW-1:0] nm2_ext;
	always_comb begin
		pu_ext = EW'(points_in_use_q);
		if (pu_ext < EW'(2)) begin
			n_c = EW'(2);
		end else if (pu_ext > EW'(MAX_POINTS)) begin
			n_c = EW'(MAX_POINTS);
		end else begin
			n_c = pu_ext;
		end
		nm2_ext = n_c - EW'(2);
	end

	// load address and range check
	logic [XW-1:0] idx_ext;
	logic load_we;
	assign idx_ext = XW'(in_idx);
	assign load_we = s_fire && (s_axis_tuser == plin_pkg::REQ_LOAD)
		&& (idx_ext < XW'(MAX_POINTS));

	// table RAM
	logic ram_re;
	logic [IW-1:0] ram_raddr;
	logic [plin_pkg::ENTRY_W-1:0] ram_rdata;
	logic signed [VW-1:0] rd_x;
	logic signed [VW-1:0] rd_y;

	plin_ram #(
		.WIDTH (plin_pkg::ENTRY_W),
		.DEPTH (MAX_POINTS)
	) u_table (
		.clk   (clk),
		.we    (load_we),
		.waddr (idx_ext[IW-1:0]),
		.wdata ({in_py, in_px}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_x = ram_rdata[VW-1:0];
	assign rd_y = ram_rdata[2*VW-1:VW];

	// search step
	logic [IW-1:0] i_inc;
	logic x_above_rd;
	assign i_inc = i_q + IW'(1);
	assign x_above_rd = (x_q > rd_x);

	always_comb begin
		ram_re = 1'b0;
		ram_raddr = i_q;
		case (state_q)
			ST_IDLE: begin
				ram_re = s_fire && (s_axis_tuser == plin_pkg::REQ_QUERY);
				ram_raddr = nm2_ext[IW-1:0];
			end
			ST_LAST: begin
				ram_re = 1'b1;
				ram_raddr = IW'(1);
			end
			ST_SRCH: begin
				ram_re = 1'b1;
				ram_raddr = i_inc + IW'(1);
			end
			ST_FETCHL: begin
				ram_re = 1'b1;
				ram_raddr = i_q;
			end
			ST_FETCHR: begin
				ram_re = 1'b1;
				ram_raddr = i_inc;
			end
			default: begin
				ram_re = 1'b0;
				ram_raddr = i_q;
			end
		endcase
	end

	// end-value clamping and differences, right entry on the read port
	logic signed [VW-1:0] yr_c;
	logic signed [VW-1:0] yl_c;
	logic signed [VW:0] dx_c;
	logic signed [VW:0] dy_c;
	logic signed [VW:0] ddx_c;
	always_comb begin
		yr_c = rd_y;
		yl_c = yl_q;
		if (!ext_q) begin
			if (x_q < xl_q) begin
				yr_c = yl_q;
			end
			if (x_q > rd_x) begin
				yl_c = yr_c;
			end
		end
		dx_c  = {rd_x[VW-1], rd_x} - {xl_q[VW-1], xl_q};
		dy_c  = {yr_c[VW-1], yr_c} - {yl_c[VW-1], yl_c};
		ddx_c = {x_q[VW-1], x_q} - {xl_q[VW-1], xl_q};
	end

	// magnitudes; each difference stays within 32 bits of magnitude
	logic signed [VW:0] dy_neg;
	logic signed [VW:0] ddx_neg;
	logic signed [VW:0] dx_neg;
	logic [VW-1:0] dy_mag;
	logic [VW-1:0] ddx_mag;
	logic [VW-1:0] dx_mag;
	assign dy_neg  = -dy_q;
	assign ddx_neg = -ddx_q;
	assign dx_neg  = -dx_q;
	assign dy_mag  = dy_q[VW]  ? dy_neg[VW-1:0]  : dy_q[VW-1:0];
	assign ddx_mag = ddx_q[VW] ? ddx_neg[VW-1:0] : ddx_q[VW-1:0];
	assign dx_mag  = dx_q[VW]  ? dx_neg[VW-1:0]  : dx_q[VW-1:0];

	// restoring divider step
	logic [VW:0] trial;
	logic [VW:0] trial_sub;
	logic trial_ge;
	assign trial = {rem_q, num_q[2*VW-1]};
	assign trial_ge = (trial >= {1'b0, div_q});
	assign trial_sub = trial - {1'b0, div_q};

	// final sum and saturation
	logic q_big;
	logic neg_eff;
	logic signed [VW+2:0] sum_c;
	logic sat_hi;
	logic sat_lo;
	always_comb begin
		q_big = (num_q > {{(VW-2){1'b0}}, 2'b10, {VW{1'b0}}});
		neg_eff = neg_q && (num_q != '0);
		if (neg_eff) begin
			sum_c = {{3{yl_q[VW-1]}}, yl_q} - {1'b0, num_q[VW+1:0]};
		end else begin
			sum_c = {{3{yl_q[VW-1]}}, yl_q} + {1'b0, num_q[VW+1:0]};
		end
		sat_hi = !sum_c[VW+2] && (sum_c[VW+1:VW-1] != 3'b000);
		sat_lo = sum_c[VW+2] && (sum_c[VW+1:VW-1] != 3'b111);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			points_in_use_q <= plin_pkg::POINTS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				points_in_use_q <= cfg_wr_data;
			end
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (m_fire) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						state_q <= (s_axis_tuser == plin_pkg::REQ_QUERY) ? ST_LAST : ST_FINISH;
					end
				end
				ST_LAST: begin
					if ((x_q >= rd_x) || (nm2_q == '0)) begin
						state_q <= ST_FETCHL;
					end else begin
						state_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					if (!x_above_rd || (i_inc == nm2_q)) begin
						state_q <= ST_FETCHL;
					end
				end
				ST_FETCHL: state_q <= ST_FETCHR;
				ST_FETCHR: state_q <= ST_PAIR;
				ST_PAIR:   state_q <= ST_MUL;
				ST_MUL: begin
					state_q <= (dx_q == '0) ? ST_FINISH : ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == plin_pkg::DIV_CNT_W'(plin_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (finish_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (finish_go) begin
			out_y_q <= res_y_q;
			out_status_q <= res_status_q;
		end
		case (state_q)
			ST_IDLE: begin
				x_q <= in_qx;
				ext_q <= in_ext;
				nm2_q <= nm2_ext[IW-1:0];
				res_y_q <= '0;
				res_status_q <= plin_pkg::ST_OK;
			end
			ST_LAST: begin
				i_q <= (x_q >= rd_x) ? nm2_q : '0;
			end
			ST_SRCH: begin
				if (x_above_rd) begin
					i_q <= i_inc;
				end
			end
			ST_FETCHR: begin
				xl_q <= rd_x;
				yl_q <= rd_y;
			end
			ST_PAIR: begin
				yl_q <= yl_c;
				dx_q <= dx_c;
				dy_q <= dy_c;
				ddx_q <= ddx_c;
			end
			ST_MUL: begin
				num_q <= (2*VW)'(dy_mag) * (2*VW)'(ddx_mag);
				div_q <= dx_mag;
				neg_q <= dy_q[VW] ^ ddx_q[VW] ^ dx_q[VW];
				rem_q <= '0;
				cnt_q <= '0;
				res_y_q <= yl_q;
				res_status_q <= plin_pkg::ST_ZERO_WIDTH;
			end
			ST_DIV: begin
				rem_q <= trial_ge ? trial_sub[VW-1:0] : trial[VW-1:0];
				num_q <= {num_q[2*VW-2:0], trial_ge};
				cnt_q <= cnt_q + plin_pkg::DIV_CNT_W'(1);
			end
			ST_SUM: begin
				if (q_big) begin
					res_y_q <= neg_eff ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
					res_status_q <= plin_pkg::ST_SATURATED;
				end else if (sat_hi) begin
					res_y_q <= {1'b0, {(VW-1){1'b1}}};
					res_status_q <= plin_pkg::ST_SATURATED;
				end else if (sat_lo) begin
					res_y_q <= {1'b1, {(VW-1){1'b0}}};
					res_status_q <= plin_pkg::ST_SATURATED;
				end else begin
					res_y_q <= sum_c[VW-1:0];
					res_status_q <= plin_pkg::ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_y_q;
	assign m_axis_tuser = out_status_q;

endmodule
`default_nettype wire

// File: rtl/core/plin_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module plin_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire                       re,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the piecewise linear interpolator top level.
`default_nettype none
module testbench;
	import plin_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam longint Q_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam longint Q_MIN = 64'shFFFF_FFFF_8000_0000;
	localparam longint Q_HUGE = 64'sh0000_0003_0000_0000;

	typedef struct {
		logic [VAL_W-1:0]    y;
		logic [STATUS_W-1:0] st;
	} answer_t;

	// Keeps its own copy of the breakpoint table and predicts each answer.
	class plin_checker;
		int bp_x[TABLE_DEPTH];
		int bp_y[TABLE_DEPTH];
		logic [CNT_IN_W-1:0] points_reg;
		answer_t expected_answers[$];
		int errors;

		function new();
			foreach (bp_x[k]) begin
				bp_x[k] = 0;
				bp_y[k] = 0;
			end
			points_reg = POINTS_RESET;
			errors = 0;
		endfunction

		function void set_points(logic [CNT_IN_W-1:0] v);
			points_reg = v;
		endfunction

		function int active_points();
			int n;
			n = int'(points_reg);
			if (n < 2) n = 2;
			if (n > TABLE_DEPTH) n = TABLE_DEPTH;
			return n;
		endfunction

		function int pending();
			return expected_answers.size();
		endfunction

		function longint unsigned magnitude(longint v);
			return (v < 0) ? -v : v;
		endfunction

		function void note_request(logic kind, logic [S_DATA_W-1:0] d);
			answer_t a;
			int n, i;
			longint x, xl, xr, yl, yr, dx, dy, ddx, sum;
			longint unsigned num, q;
			bit neg;
			a.y = '0;
			a.st = ST_OK;
			if (kind == REQ_LOAD) begin
				bp_x[d[IDX_LSB +: IDX_IN_W]] = d[PX_LSB +: VAL_W];
				bp_y[d[IDX_LSB +: IDX_IN_W]] = d[PY_LSB +: VAL_W];
			end else begin
				n = active_points();
				x = longint'($signed(d[QX_LSB +: VAL_W]));
				if (x >= longint'(bp_x[n-2])) begin
					i = n - 2;
				end else begin
					i = 0;
					while (i < n - 2 && x > longint'(bp_x[i+1])) i++;
				end
				xl = longint'(bp_x[i]);
				yl = longint'(bp_y[i]);
				xr = longint'(bp_x[i+1]);
				yr = longint'(bp_y[i+1]);
				// clamp to end values outside the interval
				if (!d[EXT_BIT]) begin
					if (x < xl) yr = yl;
					if (x > xr) yl = yr;
				end
				dx = xr - xl;
				if (dx == 0) begin
					a.y = yl[VAL_W-1:0];
					a.st = ST_ZERO_WIDTH;
				end else begin
					dy = yr - yl;
					ddx = x - xl;
					neg = ((dy < 0) != (ddx < 0)) != (dx < 0);
					num = magnitude(dy) * magnitude(ddx);
					q = num / magnitude(dx);
					if (q == 0) neg = 1'b0;
					if (q > 64'h0000_0002_0000_0000)
						sum = neg ? -Q_HUGE : Q_HUGE;
					else
						sum = neg ? yl - $signed(q) : yl + $signed(q);
					if (sum > Q_MAX) begin
						sum = Q_MAX;
						a.st = ST_SATURATED;
					end else if (sum < Q_MIN) begin
						sum = Q_MIN;
						a.st = ST_SATURATED;
					end
					a.y = sum[VAL_W-1:0];
				end
			end
			expected_answers.push_back(a);
		endfunction

		function void check_result(logic [VAL_W-1:0] y, logic [STATUS_W-1:0] st);
			answer_t a;
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected result y=%h status=%0d", $time, y, st);
				errors++;
				return;
			end
			a = expected_answers.pop_front();
			if (y !== a.y) begin
				$display("%0t: result_y expected %h actual %h", $time, a.y, y);
				errors++;
			end
			if (st !== a.st) begin
				$display("%0t: status expected %0d actual %0d", $time, a.st, st);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CNT_IN_W-1:0] cfg_wr_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [VAL_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0] m_axis_tuser;

	plin_checker sb;
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	int stall_left = 0;

	piecewise_linear_interpolator_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #4 clk = ~clk;

	// receiver: random stall bursts
	always @(negedge clk) begin
		if (stall_left == 0 && stalls_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 5);
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	// valid stays high from one transaction to the next unless a gap is drawn
	task automatic send_req(input logic kind, input logic [S_DATA_W-1:0] d);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tuser <= kind;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_request(kind, d);
	endtask

	function automatic logic [S_DATA_W-1:0] pack_req(logic [IDX_IN_W-1:0] idx,
			logic [VAL_W-1:0] px, logic [VAL_W-1:0] py, logic [VAL_W-1:0] qx, logic ext);
		logic [S_DATA_W-1:0] d;
		d = '0;
		d[IDX_LSB +: IDX_IN_W] = idx;
		d[PX_LSB +: VAL_W] = px;
		d[PY_LSB +: VAL_W] = py;
		d[QX_LSB +: VAL_W] = qx;
		d[EXT_BIT] = ext;
		return d;
	endfunction

	// unused fields carry random noise
	task automatic load_point(input int idx, input logic [VAL_W-1:0] px,
			input logic [VAL_W-1:0] py);
		send_req(REQ_LOAD, pack_req(idx[IDX_IN_W-1:0], px, py, $urandom,
			1'($urandom_range(0, 1))));
	endtask

	task automatic query_at(input logic [VAL_W-1:0] qx, input logic ext);
		send_req(REQ_QUERY, pack_req(IDX_IN_W'($urandom_range(0, TABLE_DEPTH - 1)),
			$urandom, $urandom, qx, ext));
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_points(input logic [CNT_IN_W-1:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_points(v);
	endtask

	function automatic logic [VAL_W-1:0] pick_y();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic longint pick_step();
		case ($urandom_range(0, 7))
			0: return longint'(0);  // duplicate x gives a zero-width interval
			1: return longint'($urandom_range(1, 16));
			default: return longint'($urandom_range(1, 32'h00FF_FFFF));
		endcase
	endfunction

	// writes a fresh table into entries 0 .. n-1
	task automatic load_table(input int n);
		int shape, k;
		longint xv;
		shape = $urandom_range(0, 5);
		xv = longint'($signed($urandom) >>> 2);
		if (shape == 4) xv = Q_MIN;
		for (k = 0; k < n; k++) begin
			case (shape)
				0, 1: if (k > 0) xv = xv + pick_step();
				2: if (k > 0) xv = xv - pick_step();
				3: xv = longint'($signed($urandom));
				4: if (k == n - 1) xv = Q_MAX;
					else if (k > 0)
						xv = xv + longint'($urandom_range(1, 32'h3FFF_FFFF / n));
				default: if (k > 0) xv = xv + longint'($urandom_range(1, 64));
			endcase
			load_point(k, xv[VAL_W-1:0], pick_y());
		end
	endtask

	task automatic random_req(input int n);
		int k, k2;
		logic [VAL_W-1:0] qx;
		if ($urandom_range(0, 7) == 0) begin
			load_point($urandom_range(0, TABLE_DEPTH - 1), $urandom, pick_y());
		end else begin
			k = $urandom_range(0, n - 1);
			k2 = (k < n - 1) ? k + 1 : k;
			case ($urandom_range(0, 9))
				0, 1, 2: qx = sb.bp_x[k];
				3, 4, 5: qx = sb.bp_x[k] + int'($urandom_range(0, 64)) - 32;
				6, 7: qx = 32'((longint'(sb.bp_x[k]) + longint'(sb.bp_x[k2])) / 2)
					+ int'($urandom_range(0, 8)) - 4;
				8: qx = $urandom;
				default: qx = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			endcase
			query_at(qx, 1'($urandom_range(0, 1)));
		end
	endtask

	int unsigned point_settings[12] = '{2, 0, 7, 64, 1, 127, 3, 33, 100, 16, 2, 64};

	initial begin
		int n;
		sb = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_points(CNT_IN_W'(2));

		// full-range interval
		load_point(0, 32'h8000_0000, 32'h8000_0000);
		load_point(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		query_at(32'h8000_0000, 1'b0);
		query_at(32'h7FFF_FFFF, 1'b1);
		query_at(32'h0000_0000, 1'b0);
		query_at(32'h0000_0000, 1'b1);
		// zero-width interval
		load_point(1, 32'h8000_0000, 32'h0000_0000);
		query_at(32'h0000_0005, 1'b1);
		// steep segment: saturation both ways, clamping without extrapolation
		load_point(0, 32'h0000_0000, 32'h7FFF_0000);
		load_point(1, 32'h0001_0000, 32'h8000_0000);
		query_at(32'h7FFF_FFFF, 1'b1);
		query_at(32'h8000_0000, 1'b1);
		query_at(32'h8000_0000, 1'b0);
		query_at(32'h7FFF_FFFF, 1'b0);
		// descending table
		load_point(0, 32'h0010_0000, 32'h0001_0000);
		load_point(1, 32'hFFF0_0000, 32'h0005_0000);
		query_at(32'h0000_0000, 1'b0);
		query_at(32'h0020_0000, 1'b0);
		query_at(32'h0020_0000, 1'b1);
		query_at(32'h8000_0000, 1'b1);
		query_at(32'h0010_0000, 1'b0);

		foreach (point_settings[p]) begin
			// sender holds off until every result is back, then reconfigures
			drain();
			write_points(point_settings[p][CNT_IN_W-1:0]);
			n = sb.active_points();
			if (p >= 10) begin
				gaps_on = 1'b0;
				stalls_on = 1'b0;
			end
			load_table(n);
			repeat (42) random_req(n);
		end

		drain();
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("piecewise_linear_interpolator_top test passed");
		else
			$display("piecewise_linear_interpolator_top test failed");
		$finish;
	end

	initial begin
		#8000000;
		$display("piecewise_linear_interpolator_top test failed");
		$finish;
	end
endmodule
`default_nettype wire

// File: filelist.f
rtl/core/plin_pkg.sv
rtl/core/plin_ram.sv
rtl/core/piecewise_linear_interpolator_top.sv
tb/sv/testbench.sv
